// ----- rtl/core/hex_record_text_decoder_assert.svh -----
// Assertion macros shared by the hex-record decoder RTL.
`ifndef HEX_RECORD_TEXT_DECODER_ASSERT_SVH
`define HEX_RECORD_TEXT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HRD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hrd assertion failed");
`define HRD_ASSERT_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("hrd forbidden condition seen");
`else
`define HRD_ASSERT(lbl, clk, rst, prop)
`define HRD_ASSERT_NEVER(lbl, clk, rst, prop)
`endif

`endif

// ----- rtl/core/hrd_pkg.sv -----
// Types, constants and helpers of the hex-record text decoder.
`default_nettype none
package hrd_pkg;

  localparam int COL_W = 10;
  localparam int HCL_W = 10;
  localparam logic [COL_W-1:0] COL_MAX = 10'd1023;
  localparam int DATA_START_COLUMN_DEF = 12;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] END_MARK     = 8'h1A;
  localparam logic [7:0] CR_BYTE      = 8'h0D;

  // Configuration register indexes
  localparam logic REG_STRIP_CR   = 1'b0;
  localparam logic REG_END_MARK_EN = 1'b1;

  typedef struct packed {
    logic [7:0] text_char;
    logic       file_start;
  } char_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       is_end_mark;
  } result_t;

  // Hex digit value; anything that is not a hex digit is 0.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)
      v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = c[3:0] + 4'h9;
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/hrd_if.sv -----
// Valid/ready stream interfaces for characters in and bytes out.
`default_nettype none
interface hrd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       file_start;
  modport source (output valid, output text_char, output file_start, input ready);
  modport sink (input valid, input text_char, input file_start, output ready);
endinterface

interface hrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_end_mark;
  modport source (output valid, output out_byte, output is_end_mark, input ready);
  modport sink (input valid, input out_byte, input is_end_mark, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hrd_parse.sv -----
// Record parser: column tracking, count and nibble state, byte assembly.
`default_nettype none
`include "hex_record_text_decoder_assert.svh"
module hrd_parse
  import hrd_pkg::*;
#(
  parameter int DATA_START_COLUMN = DATA_START_COLUMN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire char_item_t item,
  input  wire logic       strip_cr,
  input  wire logic       end_mark_enable,
  output result_t         res
);

  localparam logic [COL_W-1:0] DSC = COL_W'(DATA_START_COLUMN);

  logic [COL_W-1:0] column, column_next, col_base, col_inc;
  logic [HCL_W-1:0] hex_chars_left, hex_chars_left_next, hcl_base;
  logic [3:0]       high_nibble, high_nibble_next, hn_base, hv;
  logic             stopped, stopped_next;
  logic [7:0]       byte_val;

  assign hv = hex_value(item.text_char);

  always_comb begin
    col_base = item.file_start ? '0 : column;
    hcl_base = item.file_start ? '0 : hex_chars_left;
    hn_base  = item.file_start ? '0 : high_nibble;
    column_next         = col_base;
    hex_chars_left_next = hcl_base;
    high_nibble_next    = hn_base;
    stopped_next        = item.file_start ? 1'b0 : stopped;
    res      = '0;
    byte_val = {hn_base, hv};
    col_inc  = (col_base != '0 && col_base != COL_MAX) ? col_base + 1'b1 : col_base;
    if (!stopped_next) begin
      if (item.text_char == CHAR_COLON) begin
        column_next = COL_W'(1);
      end else if (item.text_char == CHAR_NEWLINE) begin
        column_next         = '0;
        hex_chars_left_next = '0;
      end else begin
        column_next = col_inc;
        if (col_inc == COL_W'(2)) begin
          high_nibble_next = hv;
        end else if (col_inc == COL_W'(3)) begin
          hex_chars_left_next = {1'b0, byte_val, 1'b0};
          if (byte_val == 8'd0) begin
            stopped_next    = 1'b1;
            res.valid       = end_mark_enable;
            res.out_byte    = END_MARK;
            res.is_end_mark = 1'b1;
          end
        end else if (col_inc >= DSC && hcl_base != '0) begin
          hex_chars_left_next = hcl_base - 1'b1;
          if ((col_inc[0] ^ DSC[0]) == 1'b0) begin
            high_nibble_next = hv;
          end else begin
            res.valid    = !(strip_cr && byte_val == CR_BYTE);
            res.out_byte = byte_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      hex_chars_left <= '0;
      high_nibble    <= '0;
      stopped        <= 1'b0;
    end else if (take) begin
      column         <= column_next;
      hex_chars_left <= hex_chars_left_next;
      high_nibble    <= high_nibble_next;
      stopped        <= stopped_next;
    end
  end

  `HRD_ASSERT(a_hcl_range, clk, rst, hex_chars_left <= HCL_W'(510))
  `HRD_ASSERT(a_end_mark_stops, clk, rst, (take && res.valid && res.is_end_mark) |=> stopped)
  `HRD_ASSERT(a_data_col, clk, rst, (take && res.valid && !res.is_end_mark) |=> column >= DSC)

endmodule
`default_nettype wire

// ----- rtl/core/hrd_outreg.sv -----
// Result register between the parser and the byte output channel.
`default_nettype none
module hrd_outreg
  import hrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  output logic         advance,
  hrd_byte_if.source   data
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic       is_end_mark;

  // Output slot frees up when empty or being taken this cycle.
  assign advance = !out_valid || data.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= res.out_byte;
      is_end_mark <= res.is_end_mark;
    end
  end

  assign data.valid       = out_valid;
  assign data.out_byte    = out_byte;
  assign data.is_end_mark = is_end_mark;

endmodule
`default_nettype wire

// ----- rtl/core/hex_record_text_decoder.sv -----
// Top level of the hex-record text decoder.
//
//   channel  dir  payload                    transaction when
//   text     in   text_char, file_start      valid && ready
//   data     out  out_byte, is_end_mark      valid && ready
//   cfg      in   cfg_index, cfg_data        cfg_we
//
// One character per cycle sustained while the output is not stalled; an input
// transaction reaches the result through the input register, then the result register.
// rst is synchronous: parse state, stop flag and valids clear, strip_cr
// and end_mark_enable return to 1.
// A stalled output holds the input register; text.ready drops only then.
`default_nettype none
module hex_record_text_decoder
  import hrd_pkg::*;
#(
  parameter int DATA_START_COLUMN = DATA_START_COLUMN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  hrd_char_if.sink  text,
  hrd_byte_if.source data,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic cfg_data
);

  logic       strip_cr, end_mark_enable;
  logic       in_valid;
  char_item_t in_item;
  logic       advance, take;
  result_t    res;

  assign take       = in_valid && advance;
  assign text.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_cr        <= 1'b1;
      end_mark_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIP_CR:    strip_cr        <= cfg_data;
        REG_END_MARK_EN: end_mark_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready) begin
      in_item.text_char  <= text.text_char;
      in_item.file_start <= text.file_start;
    end
  end

  hrd_parse #(
    .DATA_START_COLUMN(DATA_START_COLUMN)
  ) u_parse (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .item            (in_item),
    .strip_cr        (strip_cr),
    .end_mark_enable (end_mark_enable),
    .res             (res)
  );

  hrd_outreg u_outreg (
    .clk     (clk),
    .rst     (rst),
    .load    (take),
    .res     (res),
    .advance (advance),
    .data    (data)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for the hex-record text decoder: directed table, then random record streams.
`default_nettype none
module testbench;
  import hrd_pkg::*;

  localparam int FIRST_DATA_COL = DATA_START_COLUMN_DEF;
  localparam int RANDOM_ITEMS   = 720;
  localparam int PHASES         = 6;
  localparam int IDLE_LIMIT     = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int LONG_LINE_LEN  = 1030;
  localparam int DIRECTED_LEN   = 25;

  typedef struct packed {
    logic [7:0] value;
    logic       mark;
  } dec_byte_t;

  // typed = 1: the expected outcome (has, value, mark) is given in the row
  typedef struct packed {
    logic [7:0] ch;
    logic       fs;
    logic       typed;
    logic       has;
    logic [7:0] value;
    logic       mark;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{CHAR_COLON,   1'b1, 1'b1, 1'b0, 8'h00,    1'b0},
    '{"0",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"2",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},  // count 2
    '{"Z",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},  // header, incl. non-hex
    '{"z",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{8'h00,        1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{8'hFF,        1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"A",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"f",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"G",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"9",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"F",          1'b0, 1'b1, 1'b0, 8'h00,    1'b0},  // upper/lower mix
    '{"f",          1'b0, 1'b1, 1'b1, 8'hFF,    1'b0},
    '{"0",          1'b0, 1'b1, 1'b0, 8'h00,    1'b0},
    '{"D",          1'b0, 1'b1, 1'b0, 8'h00,    1'b0},  // CR byte dropped
    '{"5",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},  // checksum skipped
    '{CHAR_NEWLINE, 1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{CHAR_COLON,   1'b0, 1'b1, 1'b0, 8'h00,    1'b0},
    '{"0",          1'b0, 1'b1, 1'b0, 8'h00,    1'b0},
    '{"0",          1'b0, 1'b1, 1'b1, END_MARK, 1'b1},  // zero count
    '{"A",          1'b0, 1'b1, 1'b0, 8'h00,    1'b0},  // halted, ignored
    '{CHAR_COLON,   1'b1, 1'b0, 1'b0, 8'h00,    1'b0},  // new file
    '{"F",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},
    '{"F",          1'b0, 1'b0, 1'b0, 8'h00,    1'b0},  // max count
    '{CHAR_NEWLINE, 1'b0, 1'b0, 1'b0, 8'h00,    1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  hrd_char_if text_ch();
  hrd_byte_if byte_ch();

  hex_record_text_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .data      (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // decoder shadow state and register copies
  logic [COL_W-1:0] col_pos;
  logic [HCL_W-1:0] digits_left;
  logic [3:0]       high_digit;
  logic             halted;
  logic             cfg_strip_cr;
  logic             cfg_end_mark;

  dec_byte_t expected_bytes[$];
  int        fail_count = 0;
  int        chars_sent = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'd0;
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic fs,
                                      output bit has, output dec_byte_t res);
    logic [7:0] count;
    has = 1'b0;
    res = '0;
    if (fs) begin
      col_pos = '0;
      digits_left = '0;
      high_digit = '0;
      halted = 1'b0;
    end
    if (halted) return;
    if (c == CHAR_COLON) begin
      col_pos = COL_W'(1);
      return;
    end
    if (c == CHAR_NEWLINE) begin
      col_pos = '0;
      digits_left = '0;
      return;
    end
    if (col_pos != 0 && col_pos < COL_MAX) col_pos = col_pos + 1'b1;
    if (col_pos == 2) begin
      high_digit = nibble_of(c);
      return;
    end
    if (col_pos == 3) begin
      count = {high_digit, nibble_of(c)};
      digits_left = {1'b0, count, 1'b0};
      if (count == 0) begin
        halted = 1'b1;
        if (cfg_end_mark) begin
          has = 1'b1;
          res.value = END_MARK;
          res.mark = 1'b1;
        end
      end
      return;
    end
    if (col_pos < FIRST_DATA_COL || digits_left == 0) return;
    digits_left = digits_left - 1'b1;
    // even distance from the first data column: high digit
    if (((col_pos - FIRST_DATA_COL) & 1) == 0) begin
      high_digit = nibble_of(c);
      return;
    end
    res.value = {high_digit, nibble_of(c)};
    if (cfg_strip_cr && res.value == CR_BYTE) begin
      res = '0;
      return;
    end
    has = 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_COLON || c == CHAR_NEWLINE);
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fs, input bit typed,
                           input bit t_has, input dec_byte_t t_res);
    bit        has;
    dec_byte_t res;
    int        gap;
    text_ch.valid <= 1'b1;
    text_ch.text_char <= c;
    text_ch.file_start <= fs;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    decode_char(c, fs, has, res);
    if (typed) begin
      has = t_has;
      res = t_res;
    end
    if (has) expected_bytes.push_back(res);
    chars_sent++;
    // bursts of back-to-back characters with random gaps between
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic put_char(input logic [7:0] c, input logic fs);
    send_char(c, fs, 1'b0, 1'b0, '0);
  endtask

  task automatic wait_drain();
    text_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_STRIP_CR) cfg_strip_cr = val;
    else cfg_end_mark = val;
  endtask

  task automatic send_record(input logic fs, output bit ended_file);
    logic [7:0] count;
    logic [7:0] v;
    int         nbytes;
    int         cut;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) count = 8'd0;
    else if (roll < 11) count = 8'($urandom_range(17, 255));
    else count = 8'($urandom_range(1, 16));
    // big counts get up to 24 data bytes, so the newline usually cuts them short
    nbytes = (count > 16) ? $urandom_range(0, 24) : count;
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, nbytes) : -1;
    ended_file = (count == 0);
    put_char(CHAR_COLON, fs);
    put_char(hex_char(count[7:4]), 1'b0);
    put_char(hex_char(count[3:0]), 1'b0);
    repeat (8)
      put_char(($urandom_range(0, 4) == 0) ? stray_char()
                                           : hex_char(4'($urandom_range(0, 15))),
               1'b0);
    for (int i = 0; i < nbytes; i++) begin
      if (i == cut) begin
        put_char($urandom_range(0, 1) ? CHAR_COLON : CHAR_NEWLINE, 1'b0);
        return;
      end
      v = ($urandom_range(0, 5) == 0) ? CR_BYTE : 8'($urandom_range(0, 255));
      put_char(($urandom_range(0, 29) == 0) ? stray_char() : hex_char(v[7:4]), 1'b0);
      put_char(hex_char(v[3:0]), 1'b0);
    end
    put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
    put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
    if ($urandom_range(0, 3) == 0) put_char(CR_BYTE, 1'b0);
    put_char(CHAR_NEWLINE, 1'b0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) put_char(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
  endtask

  // max count on a line long enough to pin the column at its ceiling
  task automatic send_long_line();
    put_char(CHAR_COLON, 1'b1);
    put_char("F", 1'b0);
    put_char("F", 1'b0);
    repeat (8) put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
    repeat (LONG_LINE_LEN)
      put_char(($urandom_range(0, 29) == 0) ? stray_char()
                                            : hex_char(4'($urandom_range(0, 15))),
               1'b0);
    put_char(CHAR_NEWLINE, 1'b0);
  endtask

  initial begin : stimulus
    bit   need_fs;
    bit   ended;
    int   phase_start;
    logic s_val;
    logic e_val;
    text_ch.valid <= 1'b0;
    text_ch.text_char <= 8'h00;
    text_ch.file_start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_STRIP_CR;
    cfg_data <= 1'b0;
    rst <= 1'b1;
    col_pos = '0;
    digits_left = '0;
    high_digit = '0;
    halted = 1'b0;
    cfg_strip_cr = 1'b1;
    cfg_end_mark = 1'b1;
    need_fs = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_char(DIRECTED[i].ch, DIRECTED[i].fs, DIRECTED[i].typed, DIRECTED[i].has,
                '{DIRECTED[i].value, DIRECTED[i].mark});
    wait_drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin s_val = 1'b0; e_val = 1'b0; end
        1: begin s_val = 1'b1; e_val = 1'b1; end
        2: begin s_val = 1'b0; e_val = 1'b1; end
        3: begin s_val = 1'b1; e_val = 1'b0; end
        default: begin
          s_val = 1'($urandom_range(0, 1));
          e_val = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_STRIP_CR, s_val);
      write_reg(REG_END_MARK_EN, e_val);
      if (phase == 1) hold_req = 1'b1;
      if (phase == 3) begin
        send_long_line();
        need_fs = 1'b0;
      end
      phase_start = chars_sent;
      while (chars_sent - phase_start < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          send_record(need_fs || ($urandom_range(0, 24) == 0), ended);
          need_fs = ended;
        end
      end
      wait_drain();
    end

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    int pat_left;
    int pat_mode;
    hold_left = 0;
    pat_left = 0;
    pat_mode = 0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_ch.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(4, 60);
        end
        pat_left--;
        case (pat_mode)
          0: byte_ch.ready <= 1'b1;
          1: byte_ch.ready <= 1'($urandom_range(0, 1));
          2: byte_ch.ready <= ($urandom_range(0, 3) == 0);
          default: byte_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    dec_byte_t exp_b;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected transaction byte %h mark %b", $time,
                 byte_ch.out_byte, byte_ch.is_end_mark);
        fail_count++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (byte_ch.out_byte !== exp_b.value) begin
          $display("%0t: out_byte expected %h actual %h", $time, exp_b.value,
                   byte_ch.out_byte);
          fail_count++;
        end
        if (byte_ch.is_end_mark !== exp_b.mark) begin
          $display("%0t: is_end_mark expected %b actual %b", $time, exp_b.mark,
                   byte_ch.is_end_mark);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire
